// File: rtl/rtd_pkg.sv
// shared constants, types and helpers for the rtd resistance to temperature block
package rtd_pkg;

    // fixed field widths
    localparam int IN_W   = 19;
    localparam int TEMP_W = 21;
    localparam int CODE_W = 3;

    // default parameter values
    localparam int MAX_ITER_DEF = 50;
    localparam int FRAC_DEF     = 10;

    // callendar-van dusen coefficients scaled by 100
    localparam logic signed [63:0] KA     = 64'sd1678602068;   // q32
    localparam logic signed [63:0] KB     = 64'sd16255179905;  // q48, magnitude
    localparam logic signed [63:0] KC     = 64'sd7716273046;   // q64, magnitude
    localparam logic signed [63:0] KA_S16 = KA <<< 16;         // q48

    // q32 temperatures and ohms
    localparam logic signed [63:0] Q32_100  = 64'sd429496729600;
    localparam logic signed [63:0] Q32_M1   = -64'sd4294967296;
    localparam logic signed [63:0] Q32_M100 = -64'sd429496729600;
    localparam logic signed [63:0] Q32_M200 = -64'sd858993459200;
    localparam logic signed [63:0] Q32_850  = 64'sd3650722201600;

    // tolerances and limits
    localparam logic [63:0] RES_TOL   = 64'd4294967;
    localparam logic [63:0] STEP_TOL  = 64'd429496;
    localparam logic [63:0] CHECK_TOL = 64'd429496729;
    localparam logic [63:0] DERIV_MIN = 64'd282;
    localparam logic [63:0] QUOT_CAP  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // solution path codes
    typedef enum logic [CODE_W-1:0] {
        CODE_RANGE  = 3'd0,
        CODE_QUAD   = 3'd1,
        CODE_RES    = 3'd2,
        CODE_STEP   = 3'd3,
        CODE_LINEAR = 3'd4
    } t_code;

    // multiplier request: round(a*b / 2^s)
    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         s;
    } t_mul_req;

    // divider request: floor(n*2^s / d), or integer square root of n
    typedef struct packed {
        logic        start;
        logic        root;
        logic [63:0] n;
        logic [5:0]  s;
        logic [63:0] d;
    } t_div_req;

    // unit response
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] q;
    } t_unit_rsp;

    // magnitude of a signed 64-bit value
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] neg;
        neg = 64'(-v);
        return v[63] ? neg : 64'(v);
    endfunction

endpackage

// File: rtl/rtd_if.sv
// valid/ready stream interfaces for the resistance input and the temperature output
interface rtd_in_if;
    logic                     valid;
    logic                     ready;
    logic [rtd_pkg::IN_W-1:0] resistance;

    modport source (output valid, output resistance, input ready);
    modport sink   (input valid, input resistance, output ready);
endinterface

interface rtd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rtd_pkg::TEMP_W-1:0] temperature;
    logic [rtd_pkg::CODE_W-1:0]        path_code;

    modport source (output valid, output temperature, output path_code, input ready);
    modport sink   (input valid, input temperature, input path_code, output ready);
endinterface

// File: rtl/rtd_resistance_to_temperature.sv
// Pt100 resistance to temperature converter, inverse callendar-van dusen
// paths: out of range result, then the quadratic root (checked against the resistance
// at or below 100 ohm), then clamped newton steps; each newton step runs nine multiplies
// and one bit-serial divide on the shared units
// worst case 50 newton steps plus the linear fallback
// throughput: one item at a time, input ready only while the sequencer is idle
// reset: synchronous active low, clears the sequencer, the units and the output valid
module rtd_resistance_to_temperature import rtd_pkg::*; #(
    parameter int MAX_ITERATIONS = MAX_ITER_DEF,
    parameter int FRACTION_BITS  = FRAC_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rtd_in_if.sink           i_in_ch,
    rtd_out_if.source        o_out_ch
);

    localparam int          IW   = $clog2(MAX_ITERATIONS + 1);
    localparam int          SH   = 32 - FRACTION_BITS;
    localparam logic [31:0] R_LO = 32'(18) << FRACTION_BITS;
    localparam logic [31:0] R_HI = 32'(400) << FRACTION_BITS;
    localparam logic [31:0] R_MID = 32'(100) << FRACTION_BITS;
    localparam logic [63:0] OUT_HALF = 64'd1 << (SH - 1);
    localparam logic [63:0] NEG_LIM  = 64'd1 << (TEMP_W - 1);
    localparam logic [63:0] POS_LIM  = (64'd1 << (TEMP_W - 1)) - 64'd1;

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_RANGE  = 21'h000002,
        S_DISC_A = 21'h000004,
        S_DISC_B = 21'h000008,
        S_ROOT   = 21'h000010,
        S_QDIV   = 21'h000020,
        S_QCHK_A = 21'h000040,
        S_QCHK_B = 21'h000080,
        S_QCHK_C = 21'h000100,
        S_NI     = 21'h000200,
        S_N1     = 21'h000400,
        S_N2     = 21'h000800,
        S_N3     = 21'h001000,
        S_N4     = 21'h002000,
        S_N5     = 21'h004000,
        S_N6     = 21'h008000,
        S_N7     = 21'h010000,
        S_N8     = 21'h020000,
        S_N9     = 21'h040000,
        S_N10    = 21'h080000,
        S_FB     = 21'h100000
    } t_state;

    t_state             r_state, n_state;
    logic               r_fb_wait, n_fb_wait;
    logic               r_out_pend, n_out_pend;
    logic [IN_W-1:0]    r_rin, n_rin;
    logic signed [63:0] r_r32, n_r32;
    logic signed [63:0] r_x, n_x;
    logic signed [63:0] r_t, n_t;
    logic signed [63:0] r_t2, n_t2;
    logic signed [63:0] r_t3, n_t3;
    logic signed [63:0] r_acc, n_acc;
    logic signed [63:0] r_res, n_res;
    logic               r_neg, n_neg;
    logic [IW-1:0]      r_iter, n_iter;
    t_code              r_code, n_code;
    logic               r_ovalid;
    logic [TEMP_W-1:0]  r_otemp;
    t_code              r_ocode;

    t_mul_req  mul_req;
    t_div_req  div_req;
    t_unit_rsp mul_rsp;
    t_unit_rsp div_rsp;

    logic signed [63:0] mq;
    logic signed [63:0] dq;
    logic signed [63:0] r32_c;
    logic               out_free;
    logic [63:0]        out_m;
    logic [TEMP_W-1:0]  temp_c;

    // shared arithmetic units
    rtd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    rtd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign mq    = mul_rsp.q;
    assign dq    = r_neg ? 64'(-div_rsp.q) : div_rsp.q;
    assign r32_c = 64'(r_rin) << SH;

    // output rounding and saturation
    assign out_m  = (mag64(r_t) + OUT_HALF) >> SH;
    assign temp_c = r_t[63] ? ((out_m > NEG_LIM) ? TEMP_W'(-NEG_LIM) : TEMP_W'(-out_m))
                            : ((out_m > POS_LIM) ? TEMP_W'(POS_LIM) : TEMP_W'(out_m));

    assign out_free      = !r_ovalid || o_out_ch.ready;
    assign i_in_ch.ready = (r_state == S_IDLE) && !r_out_pend;

    // sequencer
    always_comb begin
        logic signed [63:0] d62;
        logic signed [63:0] tq;
        logic signed [63:0] diff;
        logic signed [63:0] deriv;
        logic signed [63:0] tn;
        logic signed [63:0] tc;
        d62  = r_acc - mq;
        tq   = dq;
        diff = r_acc - mq;
        deriv = r_acc + (mq <<< 8) + (mq <<< 5) + (mq <<< 3) + (mq <<< 2);
        tn   = r_t - dq;
        if (tn < Q32_M200) begin
            tc = Q32_M200;
        end else if (tn > Q32_850) begin
            tc = Q32_850;
        end else begin
            tc = tn;
        end

        n_state    = r_state;
        n_fb_wait  = r_fb_wait;
        n_out_pend = r_out_pend;
        n_rin  = r_rin;
        n_r32  = r_r32;
        n_x    = r_x;
        n_t    = r_t;
        n_t2   = r_t2;
        n_t3   = r_t3;
        n_acc  = r_acc;
        n_res  = r_res;
        n_neg  = r_neg;
        n_iter = r_iter;
        n_code = r_code;
        mul_req = '0;
        div_req = '0;

        if (r_out_pend) begin
            // hold the finished result until the output register frees
            if (out_free) begin
                n_out_pend = 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_ch.valid) begin
                        n_rin   = i_in_ch.resistance;
                        n_state = S_RANGE;
                    end
                end
                S_RANGE: begin
                    if (32'(r_rin) < R_LO || 32'(r_rin) > R_HI) begin
                        n_t        = '0;
                        n_code     = CODE_RANGE;
                        n_out_pend = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_r32   = r32_c;
                        n_x     = r32_c - Q32_100;
                        mul_req = '{start: 1'b1, a: KA, b: KA, s: 6'd2};
                        n_state = S_DISC_A;
                    end
                end
                S_DISC_A: begin
                    if (mul_rsp.done) begin
                        n_acc   = mq;
                        mul_req = '{start: 1'b1, a: KB, b: r_x, s: 6'd16};
                        n_state = S_DISC_B;
                    end
                end
                S_DISC_B: begin
                    if (mul_rsp.done) begin
                        if (d62[63]) begin
                            n_state = S_NI;
                        end else begin
                            div_req = '{start: 1'b1, root: 1'b1, n: d62, s: 6'd0, d: 64'd0};
                            n_state = S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    if (div_rsp.done) begin
                        div_req = '{start: 1'b1, root: 1'b0, n: mag64(r_x <<< 1), s: 6'd32,
                                    d: KA + (div_rsp.q << 1)};
                        n_neg   = r_x[63];
                        n_state = S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (div_rsp.done) begin
                        n_t = tq;
                        if (tq >= Q32_M1 && tq <= Q32_850) begin
                            if (32'(r_rin) > R_MID) begin
                                n_code     = CODE_QUAD;
                                n_out_pend = 1'b1;
                                n_state    = S_IDLE;
                            end else begin
                                mul_req = '{start: 1'b1, a: tq, b: tq, s: 6'd32};
                                n_state = S_QCHK_A;
                            end
                        end else begin
                            n_state = S_NI;
                        end
                    end
                end
                S_QCHK_A: begin
                    if (mul_rsp.done) begin
                        n_t2    = mq;
                        n_acc   = Q32_100 - r_r32;
                        mul_req = '{start: 1'b1, a: KA, b: r_t, s: 6'd32};
                        n_state = S_QCHK_B;
                    end
                end
                S_QCHK_B: begin
                    if (mul_rsp.done) begin
                        n_acc   = r_acc + mq;
                        mul_req = '{start: 1'b1, a: KB, b: r_t2, s: 6'd48};
                        n_state = S_QCHK_C;
                    end
                end
                S_QCHK_C: begin
                    if (mul_rsp.done) begin
                        if (mag64(diff) <= CHECK_TOL) begin
                            n_code     = CODE_QUAD;
                            n_out_pend = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_NI;
                        end
                    end
                end
                // newton start point
                S_NI: begin
                    n_t     = Q32_M100;
                    n_iter  = '0;
                    mul_req = '{start: 1'b1, a: Q32_M100, b: Q32_M100, s: 6'd32};
                    n_state = S_N1;
                end
                S_N1: begin
                    if (mul_rsp.done) begin
                        n_t2    = mq;
                        mul_req = '{start: 1'b1, a: mq, b: r_t, s: 6'd32};
                        n_state = S_N2;
                    end
                end
                S_N2: begin
                    if (mul_rsp.done) begin
                        n_t3    = mq;
                        mul_req = '{start: 1'b1, a: KC, b: mq, s: 6'd48};
                        n_state = S_N3;
                    end
                end
                S_N3: begin
                    if (mul_rsp.done) begin
                        n_acc   = Q32_100 - r_r32;
                        mul_req = '{start: 1'b1, a: mq, b: r_t - Q32_100, s: 6'd48};
                        n_state = S_N4;
                    end
                end
                S_N4: begin
                    if (mul_rsp.done) begin
                        n_acc   = r_acc - mq;
                        mul_req = '{start: 1'b1, a: KA, b: r_t, s: 6'd32};
                        n_state = S_N5;
                    end
                end
                S_N5: begin
                    if (mul_rsp.done) begin
                        n_acc   = r_acc + mq;
                        mul_req = '{start: 1'b1, a: KB, b: r_t2, s: 6'd48};
                        n_state = S_N6;
                    end
                end
                // residual check, then derivative
                S_N6: begin
                    if (mul_rsp.done) begin
                        n_res = diff;
                        if (mag64(diff) <= RES_TOL) begin
                            n_code     = CODE_RES;
                            n_out_pend = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_acc   = KA_S16;
                            mul_req = '{start: 1'b1, a: KB, b: r_t, s: 6'd31};
                            n_state = S_N7;
                        end
                    end
                end
                S_N7: begin
                    if (mul_rsp.done) begin
                        n_acc   = r_acc - mq;
                        mul_req = '{start: 1'b1, a: KC, b: r_t3, s: 6'd46};
                        n_state = S_N8;
                    end
                end
                S_N8: begin
                    if (mul_rsp.done) begin
                        n_acc   = r_acc - mq;
                        mul_req = '{start: 1'b1, a: KC, b: r_t2, s: 6'd48};
                        n_state = S_N9;
                    end
                end
                S_N9: begin
                    if (mul_rsp.done) begin
                        if (mag64(deriv) < DERIV_MIN) begin
                            n_state = S_FB;
                        end else begin
                            div_req = '{start: 1'b1, root: 1'b0, n: mag64(r_res), s: 6'd48,
                                        d: mag64(deriv)};
                            n_neg   = r_res[63] ^ deriv[63];
                            n_state = S_N10;
                        end
                    end
                end
                // step, clamp and convergence
                S_N10: begin
                    if (div_rsp.done) begin
                        n_t = tc;
                        if (mag64(dq) <= STEP_TOL) begin
                            n_code     = CODE_STEP;
                            n_out_pend = 1'b1;
                            n_state    = S_IDLE;
                        end else if (r_iter == IW'(MAX_ITERATIONS - 1)) begin
                            n_state = S_FB;
                        end else begin
                            n_iter  = r_iter + IW'(1);
                            mul_req = '{start: 1'b1, a: tc, b: tc, s: 6'd32};
                            n_state = S_N1;
                        end
                    end
                end
                // linear fallback
                S_FB: begin
                    if (!r_fb_wait) begin
                        div_req   = '{start: 1'b1, root: 1'b0, n: mag64(r_x), s: 6'd32, d: KA};
                        n_neg     = r_x[63];
                        n_fb_wait = 1'b1;
                    end else if (div_rsp.done) begin
                        n_t        = tq;
                        n_code     = CODE_LINEAR;
                        n_fb_wait  = 1'b0;
                        n_out_pend = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fb_wait  <= 1'b0;
            r_out_pend <= 1'b0;
            r_iter     <= '0;
        end else begin
            r_state    <= n_state;
            r_fb_wait  <= n_fb_wait;
            r_out_pend <= n_out_pend;
            r_iter     <= n_iter;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rin  <= n_rin;
        r_r32  <= n_r32;
        r_x    <= n_x;
        r_t    <= n_t;
        r_t2   <= n_t2;
        r_t3   <= n_t3;
        r_acc  <= n_acc;
        r_res  <= n_res;
        r_neg  <= n_neg;
        r_code <= n_code;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_out_pend && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_pend && out_free) begin
            r_otemp <= temp_c;
            r_ocode <= r_code;
        end
    end

    assign o_out_ch.valid       = r_ovalid;
    assign o_out_ch.temperature = r_otemp;
    assign o_out_ch.path_code   = r_ocode;

    // checks
    a_accept_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |-> !(mul_rsp.busy || div_rsp.busy))
        else $error("input transfer while an arithmetic unit is busy");

    a_one_unit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && div_req.start))
        else $error("multiplier and divider started together");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter < IW'(MAX_ITERATIONS))
        else $error("newton step count beyond limit");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.path_code == CODE_RANGE) |-> o_out_ch.temperature == '0)
        else $error("out of range result with non-zero temperature");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> o_out_ch.path_code <= CODE_LINEAR)
        else $error("illegal path code on output");

endmodule

// File: rtl/rtd_mul.sv
// multi-cycle signed 64x64 multiplier with rounded right shift and saturation
module rtd_mul import rtd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mul_req  i_req,
    output t_unit_rsp o_rsp
);

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_PROD  = 4'b0010,
        M_ROUND = 4'b0100,
        M_SHIFT = 4'b1000
    } t_mstate;

    t_mstate      r_state;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    logic [5:0]   r_s;
    logic [1:0]   r_idx;
    logic [128:0] r_acc;
    logic [63:0]  r_q;
    logic         r_done;

    logic [31:0]  a_sel;
    logic [31:0]  b_sel;
    logic [63:0]  prod;
    logic [6:0]   pp_amt;
    logic [128:0] pp_shift;
    logic [128:0] shifted;
    logic [63:0]  mag_q;

    // one 32x32 partial product per cycle
    assign a_sel    = r_idx[1] ? r_ua[63:32] : r_ua[31:0];
    assign b_sel    = r_idx[0] ? r_ub[63:32] : r_ub[31:0];
    assign prod     = a_sel * b_sel;
    assign pp_amt   = 7'({1'b0, r_idx[1]} + {1'b0, r_idx[0]}) << 5;
    assign pp_shift = 129'(prod) << pp_amt;

    // final shift with saturation of the magnitude
    assign shifted = r_acc >> r_s;
    assign mag_q   = (|shifted[128:63]) ? INT64_MAX : {1'b0, shifted[62:0]};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_ua    <= mag64(i_req.a);
                        r_ub    <= mag64(i_req.b);
                        r_neg   <= i_req.a[63] ^ i_req.b[63];
                        r_s     <= i_req.s;
                        r_acc   <= '0;
                        r_idx   <= 2'd0;
                        r_state <= M_PROD;
                    end
                end
                M_PROD: begin
                    r_acc <= r_acc + pp_shift;
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_state <= M_ROUND;
                    end
                end
                M_ROUND: begin
                    r_acc   <= r_acc + (129'(1) << (r_s - 6'd1));
                    r_state <= M_SHIFT;
                end
                M_SHIFT: begin
                    r_q     <= r_neg ? 64'(-mag_q) : mag_q;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.busy = (r_state != M_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

// File: rtl/rtd_div.sv
// bit-serial restoring divider with saturation, also runs an integer square root
module rtd_div import rtd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_unit_rsp o_rsp
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } t_dstate;

    t_dstate     r_state;
    logic        r_root;
    logic [63:0] r_n;     // dividend shifter, or the root's trial bit
    logic [63:0] r_d;
    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic        r_sat;
    logic [6:0]  r_cnt;
    logic        r_done;

    logic [63:0] rem_sh;
    logic        ge;
    logic [63:0] q_div;
    logic [63:0] trial;
    logic        fits;

    // one quotient bit
    assign rem_sh = {r_rem[62:0], r_n[63]};
    assign ge     = (rem_sh >= r_d);
    assign q_div  = {r_q[62:0], ge};

    // one root bit
    assign trial = r_q + r_n;
    assign fits  = (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= 7'd0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_root <= i_req.root;
                        r_d    <= i_req.d;
                        r_q    <= '0;
                        if (i_req.root) begin
                            r_rem <= i_req.n;
                            r_n   <= 64'h4000_0000_0000_0000;
                            r_sat <= 1'b0;
                            r_cnt <= 7'd32;
                        end else begin
                            r_rem <= '0;
                            r_n   <= i_req.n;
                            r_sat <= (i_req.d == 64'd0) || i_req.d[63];
                            r_cnt <= 7'd64 + {1'b0, i_req.s};
                        end
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_root) begin
                        if (fits) begin
                            r_rem <= r_rem - trial;
                            r_q   <= (r_q >> 1) + r_n;
                        end else begin
                            r_q <= r_q >> 1;
                        end
                        r_n <= r_n >> 2;
                    end else begin
                        r_rem <= ge ? (rem_sh - r_d) : rem_sh;
                        r_q   <= q_div;
                        r_n   <= r_n << 1;
                        if (q_div > QUOT_CAP) begin
                            r_sat <= 1'b1;
                        end
                    end
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.busy = (r_state != D_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_sat ? QUOT_CAP : r_q;

endmodule

// File: bench/rtd_checker.sv
// checker for the rtd converter: predicts each temperature and compares the output transfers
module rtd_checker import rtd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rtd_in_if    i_in_ch,
    rtd_out_if   i_out_ch,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_path_seen [5]
);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        t_code                    code;
    } t_reading;

    t_reading readings_due[$];
    int       fails;

    // round(a*b / 2^s), ties away from zero, magnitude saturated
    function automatic logic signed [63:0] rnd_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int s);
        logic [127:0] p;
        logic [63:0]  r;
        p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        r = (p > {64'd0, INT64_MAX}) ? INT64_MAX : p[63:0];
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    // floor(n * 2^s / d), saturated at the quotient cap
    function automatic logic [63:0] frac_div(input logic [63:0] n, input int s,
                                             input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        logic        bit_in;
        q = 0;
        r = 0;
        if (d == 0 || d[63]) return QUOT_CAP;
        for (int i = 0; i < 64 + s; i++) begin
            bit_in = (i < 64) ? n[63-i] : 1'b0;
            r = {r[62:0], bit_in};
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
            if (q > QUOT_CAP) return QUOT_CAP;
        end
        return q;
    endfunction

    function automatic logic signed [63:0] sdiv(input logic signed [63:0] num, input int s,
                                                input logic signed [63:0] den);
        logic [63:0] q;
        q = frac_div(mag64(num), s, mag64(den));
        return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] one;
        res = 0;
        one = 64'd1 << 62;
        while (one > v) one = one >> 2;
        while (one != 0) begin
            if (v >= res + one) begin
                v = v - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] quad_ohm(input logic signed [63:0] t);
        logic signed [63:0] t2;
        t2 = rnd_mul(t, t, 32);
        return Q32_100 + rnd_mul(KA, t, 32) - rnd_mul(KB, t2, 48);
    endfunction

    function automatic logic signed [63:0] cubic_ohm(input logic signed [63:0] t);
        logic signed [63:0] t2, t3, ct3, ct4;
        t2  = rnd_mul(t, t, 32);
        t3  = rnd_mul(t2, t, 32);
        ct3 = rnd_mul(KC, t3, 48);
        ct4 = rnd_mul(ct3, t - Q32_100, 48);
        return Q32_100 + rnd_mul(KA, t, 32) - rnd_mul(KB, t2, 48) - ct4;
    endfunction

    function automatic logic signed [63:0] cubic_slope(input logic signed [63:0] t);
        logic signed [63:0] t2, t3;
        t2 = rnd_mul(t, t, 32);
        t3 = rnd_mul(t2, t, 32);
        return KA_S16 - rnd_mul(KB, t, 31) - rnd_mul(KC, t3, 46)
               + 64'sd300 * rnd_mul(KC, t2, 48);
    endfunction

    // q32 to the output format, rounded and saturated
    function automatic logic signed [TEMP_W-1:0] to_temp(input logic signed [63:0] t);
        logic [63:0] m;
        m = (mag64(t) + (64'd1 << 21)) >> 22;
        if (t < 0) return (m > (64'd1 << 20)) ? -21'sd1048576 : -$signed(m[20:0]);
        return (m > 64'd1048575) ? 21'sd1048575 : $signed(m[20:0]);
    endfunction

    function automatic t_reading convert(input logic [IN_W-1:0] rin);
        t_reading           rd;
        logic signed [63:0] r32, x, d62, den, t, res, slope, delta;
        t_code              code;
        code = CODE_LINEAR;
        if (rin < (19'd18 << 10) || rin > (19'd400 << 10)) begin
            rd.temperature = '0;
            rd.code = CODE_RANGE;
            return rd;
        end
        r32 = $signed({23'd0, rin, 22'd0});
        x = r32 - Q32_100;
        // quadratic root first
        d62 = rnd_mul(KA, KA, 2) - rnd_mul(KB, x, 16);
        if (d62 >= 0) begin
            den = KA + 2 * $signed(int_root(d62));
            t = sdiv(2 * x, 32, den);
            if (t >= Q32_M1 && t <= Q32_850) begin
                if (rin > (19'd100 << 10) || mag64(quad_ohm(t) - r32) <= CHECK_TOL) begin
                    rd.temperature = to_temp(t);
                    rd.code = CODE_QUAD;
                    return rd;
                end
            end
        end
        // clamped newton on the full equation
        t = Q32_M100;
        for (int i = 0; i < MAX_ITER_DEF; i++) begin
            res = cubic_ohm(t) - r32;
            if (mag64(res) <= RES_TOL) begin
                code = CODE_RES;
                break;
            end
            slope = cubic_slope(t);
            if (mag64(slope) < DERIV_MIN) break;
            delta = sdiv(res, 48, slope);
            t = t - delta;
            if (t < Q32_M200) t = Q32_M200;
            else if (t > Q32_850) t = Q32_850;
            if (mag64(delta) <= STEP_TOL) begin
                code = CODE_STEP;
                break;
            end
        end
        if (code == CODE_LINEAR) t = sdiv(x, 32, KA);
        rd.temperature = to_temp(t);
        rd.code = code;
        return rd;
    endfunction

    initial begin
        fails = 0;
        for (int k = 0; k < 5; k++) o_path_seen[k] = 0;
    end

    // predict on every input transfer, compare on every output transfer
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n) begin
            if (i_in_ch.valid && i_in_ch.ready)
                readings_due.push_back(convert(i_in_ch.resistance));
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: unexpected result temperature %0d code %0d", $time,
                             i_out_ch.temperature, i_out_ch.path_code);
                    fails++;
                end else begin
                    want = readings_due.pop_front();
                    if (want.code <= CODE_LINEAR) o_path_seen[want.code]++;
                    if (i_out_ch.temperature !== want.temperature) begin
                        $display("%0t: temperature expected %0d actual %0d", $time,
                                 want.temperature, i_out_ch.temperature);
                        fails++;
                    end
                    if (i_out_ch.path_code !== want.code) begin
                        $display("%0t: path code expected %0d actual %0d", $time,
                                 want.code, i_out_ch.path_code);
                        fails++;
                    end
                end
            end
        end
    end

    assign o_mismatches = fails;
    assign o_pending    = readings_due.size();

endmodule

// File: bench/tb.sv
// testbench top for the rtd converter: clock, reset, stimulus, back-pressure and verdict
module tb import rtd_pkg::*; ();

    logic i_clk;
    logic i_rst_n;
    int   mismatch_total;
    int   pending;
    int   path_seen [5];
    int   out_transfers;
    bit   quiet;
    int   n_items;

    rtd_in_if  in_ch ();
    rtd_out_if out_ch ();

    rtd_resistance_to_temperature dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    rtd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_mismatches (mismatch_total),
        .o_pending    (pending),
        .o_path_seen  (path_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // count output transfers for the long receiver hold
    initial out_transfers = 0;
    always @(posedge i_clk) if (out_ch.valid && out_ch.ready) out_transfers++;

    // random resistance, mostly in the working range
    function automatic logic [IN_W-1:0] pick_resistance();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 19'($urandom_range(100 << 10, 400 << 10));
        if (sel < 80) return 19'($urandom_range(18 << 10, 100 << 10));
        if (sel < 88) return 19'($urandom_range((18 << 10) - 8, (18 << 10) + 8));
        if (sel < 93) return 19'($urandom_range((400 << 10) - 8, (400 << 10) + 8));
        return 19'($urandom);
    endfunction

    // one input transfer, with an optional gap in front
    task automatic send_resistance(input logic [IN_W-1:0] r);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.resistance <= r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_items++;
    endtask

    // receiver: random stall bursts and one long hold
    initial begin
        int  hold;
        bit  long_done;
        hold = 0;
        long_done = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_done && out_transfers == 20) begin
                long_done = 1;
                hold = 3000;
            end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 7);
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [IN_W-1:0] directed [] = '{
            19'd0, 19'h7FFFF, (19'd18 << 10) - 19'd1, 19'd18 << 10,
            (19'd18 << 10) + 19'd1, 19'd100 << 10, (19'd100 << 10) + 19'd1,
            (19'd100 << 10) - 19'd1, 19'd400 << 10, (19'd400 << 10) + 19'd1,
            19'd50 << 10, 19'd80 << 10, 19'd99 << 10, 19'd138 << 10,
            19'd250 << 10, 19'd390 << 10, 19'h55555, 19'h2AAAA, 19'd20 << 10
        };
        quiet = 0;
        n_items = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.resistance = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_resistance(directed[k]);
        for (int k = 0; k < 300; k++) begin
            if (k == 260) quiet = 1;
            send_resistance(pick_resistance());
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("run covered %0d resistances across the range limits and both sides of 100 ohm",
                 n_items);
        $display("paths: range %0d quadratic %0d residual %0d step %0d linear %0d",
                 path_seen[0], path_seen[1], path_seen[2], path_seen[3], path_seen[4]);
        if (mismatch_total == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #40000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/rtd_pkg.sv
rtl/rtd_if.sv
rtl/rtd_mul.sv
rtl/rtd_div.sv
rtl/rtd_resistance_to_temperature.sv
bench/rtd_checker.sv
bench/tb.sv
